>>> design/dpfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfr_pkg
// Shared types and constants for the demand page frame replacer.
// ----------------------------------------------------------------------------
package dpfr_pkg;

  // default geometry
  localparam int unsigned DefPages     = 128;
  localparam int unsigned DefFrames    = 90;
  localparam int unsigned DefPageShift = 13;

  // field widths
  localparam int unsigned VaddrW    = 31;
  localparam int unsigned RandW     = 32;
  localparam int unsigned BaseW     = 29;
  localparam int unsigned PageOutW  = 7;
  localparam int unsigned FrameOutW = 7;
  localparam int unsigned RomOffW   = 24;
  localparam int unsigned PageIdxW  = 11;
  localparam int unsigned CtxW      = 23;
  localparam int unsigned CountW    = 32;

  // tag placed over an evicted page's unmap address
  localparam logic [VaddrW-1:0] EvictTag = 31'h7F00_0000;
  // flag bits in the low part of a page table word
  localparam logic [5:0]        CtxFlags = 6'h1F;

  // command codes
  typedef enum logic [0:0] {
    CMD_FAULT = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

endpackage

>>> design/demand_page_frame_replacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_page_frame_replacer
// Random replacement frame allocator for on-demand ROM pages.
// ----------------------------------------------------------------------------
// Three register stages: the input register also holds the reciprocal
// product for random_word mod FRAMES, the second stage holds the chosen frame
// and the registered frame table read, the third is the result register.
// A transaction is accepted every cycle unless the output stalls; its result
// passes stage b and the result register, the table read register setting the
// depth. The frame occupancy bits clear at reset, so no clearing pass is needed.
// The page table itself lives outside: each fault reports the context word to
// write at page_index and the evicted page whose entry goes back to 1.
// ----------------------------------------------------------------------------
module demand_page_frame_replacer #(
  parameter int unsigned PAGES      = dpfr_pkg::DefPages,
  parameter int unsigned FRAMES     = dpfr_pkg::DefFrames,
  parameter int unsigned PAGE_SHIFT = dpfr_pkg::DefPageShift
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dpfr_pkg::BaseW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic [dpfr_pkg::VaddrW-1:0]        fault_address_i,
  input  logic [dpfr_pkg::RandW-1:0]         random_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [dpfr_pkg::VaddrW-1:0]        unmap_fault_hi_o,
  output logic                               evict_valid_o,
  output logic [dpfr_pkg::VaddrW-1:0]        evict_hi_o,
  output logic [dpfr_pkg::PageOutW-1:0]      evicted_page_o,
  output logic [dpfr_pkg::FrameOutW-1:0]     chosen_frame_o,
  output logic [dpfr_pkg::RomOffW-1:0]       rom_offset_o,
  output logic [dpfr_pkg::PageIdxW-1:0]      page_index_o,
  output logic [dpfr_pkg::CtxW-1:0]          new_context_o,
  output logic                               page_out_of_range_o,
  output logic [dpfr_pkg::CountW-1:0]        fault_count_o
);
  import dpfr_pkg::*;

  localparam int unsigned FidxW = $clog2(FRAMES);
  localparam int unsigned PidxW = $clog2(PAGES);
  localparam int unsigned PhysW = 30;
  // floor(2^32 / FRAMES): quotient estimate is short by at most one
  localparam longint unsigned RecipL = (64'd1 << 32) / FRAMES;
  localparam logic [31:0] Recip   = 32'(RecipL);
  localparam logic [31:0] FramesU = 32'(FRAMES);
  localparam logic [VaddrW-1:0]  InPageMask = VaddrW'((32'd1 << PAGE_SHIFT) - 32'd1);
  localparam logic [RomOffW-1:0] PagesU     = RomOffW'(PAGES);

  // configuration register
  logic [BaseW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // handshake chain
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_adv, b_adv, b_ready, c_ready;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_adv      = b_valid_q && c_ready;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_adv      = a_valid_q && b_ready;
  assign in_ready_o = !a_valid_q || b_ready;

  // stage a: input register with the reciprocal product
  cmd_e              a_cmd_q;
  logic [VaddrW-1:0] a_addr_q;
  logic [31:0]       a_rnd_q;
  logic [31:0]       a_quot_q;
  logic [63:0]       recip_prod;

  assign recip_prod = {32'd0, random_word_i} * {32'd0, Recip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_cmd_q  <= cmd_e'(cmd_i);
      a_addr_q <= fault_address_i;
      a_rnd_q  <= random_word_i;
      a_quot_q <= recip_prod[63:32];
    end
  end

  // remainder with one correction step
  logic [31:0]      rem_raw;
  logic [31:0]      rem_fix;
  logic [FidxW-1:0] a_frame;

  assign rem_raw = a_rnd_q - (a_quot_q * FramesU);
  assign rem_fix = (rem_raw >= FramesU) ? (rem_raw - FramesU) : rem_raw;
  assign a_frame = rem_fix[FidxW-1:0];

  // stage b: chosen frame plus table read
  cmd_e              b_cmd_q;
  logic [VaddrW-1:0] b_addr_q;
  logic [FidxW-1:0]  b_frame_q;
  logic              tbl_used;
  logic [PidxW-1:0]  tbl_page;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_cmd_q   <= a_cmd_q;
      b_addr_q  <= a_addr_q;
      b_frame_q <= a_frame;
    end
  end

  // page address decode
  logic [VaddrW-1:0]  aligned;
  logic [RomOffW-1:0] rom_off;
  logic [RomOffW-1:0] page_full;
  logic [PidxW-1:0]   page_idx;
  logic               oor;
  logic               is_fault;

  assign is_fault  = (b_cmd_q == CMD_FAULT);
  assign aligned   = b_addr_q & ~InPageMask;
  assign rom_off   = aligned[RomOffW-1:0];
  assign page_full = rom_off >> PAGE_SHIFT;
  assign page_idx  = page_full[PidxW-1:0];
  assign oor       = (page_full >= PagesU);

  dpfr_frame_table #(
    .FRAMES (FRAMES),
    .PAGES  (PAGES)
  ) u_frame_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (a_adv),
    .rd_frame_i (a_frame),
    .rd_used_o  (tbl_used),
    .rd_page_o  (tbl_page),
    .wr_en_i    (b_adv && is_fault),
    .wr_frame_i (b_frame_q),
    .wr_used_i  (!oor),
    .wr_page_i  (page_idx)
  );

  // eviction and context word
  logic [VaddrW-1:0] ev_hi;
  logic [PhysW-1:0]  phys;
  logic [CtxW-1:0]   ctx;

  assign ev_hi = EvictTag | (VaddrW'(tbl_page) << PAGE_SHIFT);
  assign phys  = PhysW'(base_q) + (PhysW'(b_frame_q) << PAGE_SHIFT);
  assign ctx   = {phys[28:12], CtxFlags};

  // fault counter
  logic [CountW-1:0] cnt_q, cnt_d;

  assign cnt_d = is_fault ? (cnt_q + CountW'(1)) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (b_adv) begin
      cnt_q <= cnt_d;
    end
  end

  // stage c: result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      fault_count_o <= cnt_d;
      if (is_fault) begin
        unmap_fault_hi_o    <= aligned;
        evict_valid_o       <= tbl_used;
        evict_hi_o          <= tbl_used ? ev_hi : '0;
        evicted_page_o      <= tbl_used ? PageOutW'(tbl_page) : '0;
        chosen_frame_o      <= FrameOutW'(b_frame_q);
        rom_offset_o        <= rom_off;
        page_index_o        <= page_full[PageIdxW-1:0];
        new_context_o       <= ctx;
        page_out_of_range_o <= oor;
      end else begin
        unmap_fault_hi_o    <= '0;
        evict_valid_o       <= 1'b0;
        evict_hi_o          <= '0;
        evicted_page_o      <= '0;
        chosen_frame_o      <= '0;
        rom_offset_o        <= '0;
        page_index_o        <= '0;
        new_context_o       <= '0;
        page_out_of_range_o <= 1'b0;
      end
    end
  end

  assign out_valid_o = c_valid_q;

endmodule

>>> design/dpfr_frame_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpfr_frame_table
// Frame occupancy bits and the page held by each frame, with write-first read.
// ----------------------------------------------------------------------------
module dpfr_frame_table #(
  parameter int unsigned FRAMES = dpfr_pkg::DefFrames,
  parameter int unsigned PAGES  = dpfr_pkg::DefPages
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(FRAMES)-1:0]  rd_frame_i,
  output logic                       rd_used_o,
  output logic [$clog2(PAGES)-1:0]   rd_page_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(FRAMES)-1:0]  wr_frame_i,
  input  logic                       wr_used_i,
  input  logic [$clog2(PAGES)-1:0]   wr_page_i
);
  import dpfr_pkg::*;

  localparam int unsigned PidxW = $clog2(PAGES);

  logic             used_q [FRAMES];
  logic [PidxW-1:0] page_mem [FRAMES];
  logic             rd_used_q;
  logic [PidxW-1:0] rd_page_q;
  logic             bypass;

  // a read of the frame being written this cycle sees the new contents
  assign bypass = wr_en_i && (rd_frame_i == wr_frame_i);

  // occupancy bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        used_q[i] <= 1'b0;
      end
    end else if (wr_en_i) begin
      used_q[wr_frame_i] <= wr_used_i;
    end
  end

  // page memory, only meaningful where the occupancy bit is set
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_used_i) begin
      page_mem[wr_frame_i] <= wr_page_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (bypass) begin
        rd_used_q <= wr_used_i;
        rd_page_q <= wr_page_i;
      end else begin
        rd_used_q <= used_q[rd_frame_i];
        rd_page_q <= page_mem[rd_frame_i];
      end
    end
  end

  assign rd_used_o = rd_used_q;
  assign rd_page_o = rd_page_q;

endmodule
